// ----- sv/gph_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the GTP-U header parser.
package gph_pkg;

   localparam int MAX_EXT_HEADERS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF     = 4;
   localparam int EXT_COUNT_W         = 4;
   localparam int CSR_INDEX_W         = 2;

   localparam logic [1:0] KIND_HDR = 2'd0;
   localparam logic [1:0] KIND_PAY = 2'd1;
   localparam logic [1:0] KIND_ERR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_UDP_EXT_TYPE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PDCP_EXT_TYPE = CSR_INDEX_W'(1);

   localparam logic [7:0] UDP_EXT_TYPE_RESET  = 8'd64;
   localparam logic [7:0] PDCP_EXT_TYPE_RESET = 8'd192;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [7:0]  payload_byte;
      logic        last_of_packet;
      logic [2:0]  hdr_version;
      logic [7:0]  message_type;
      logic [15:0] message_length;
      logic [31:0] tunnel_id;
      logic [3:0]  present_flags;
      logic [15:0] sequence_number;
      logic [7:0]  npdu_number;
      logic [15:0] udp_port_value;
      logic [15:0] pdcp_number_value;
   } rsp_type;

   typedef struct packed {
      logic [7:0] udp_port_ext_type;
      logic [7:0] pdcp_number_ext_type;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- sv/gph_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts packet beats, walks the header and queues one record per event.
module gph_front #(
   parameter int MAX_EXT_HEADERS = gph_pkg::MAX_EXT_HEADERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gph_pkg::req_type req_data,
   input  gph_pkg::cfg_type cfg,
   input  gph_pkg::qstat_type qstat,
   output logic             push,
   output gph_pkg::rsp_type push_data
);

   localparam logic [3:0] PH_FIXED   = 4'd0;
   localparam logic [3:0] PH_OPT     = 4'd1;
   localparam logic [3:0] PH_NEXT    = 4'd2;
   localparam logic [3:0] PH_EXTLEN  = 4'd3;
   localparam logic [3:0] PH_EXTBODY = 4'd4;
   localparam logic [3:0] PH_PAYLOAD = 4'd5;
   localparam logic [3:0] PH_DISCARD = 4'd6;

   localparam logic [gph_pkg::EXT_COUNT_W-1:0] EXT_LIMIT =
      gph_pkg::EXT_COUNT_W'(MAX_EXT_HEADERS);

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [31:0] tunnel_ff, tunnel_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  npdu_ff, npdu_in;
   logic [15:0] udp_ff, udp_in;
   logic [15:0] pdcp_ff, pdcp_in;
   logic [3:0]  present_ff, present_in;
   logic [7:0]  ext_type_ff, ext_type_in;
   logic [9:0]  skip_ff, skip_in;
   logic [gph_pkg::EXT_COUNT_W-1:0] count_ff, count_in;

   logic       accept;
   logic       done;
   logic       err;
   logic       clear;
   logic       in_header;
   logic [7:0] b;
   logic       eop;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.data_byte;
   assign eop       = req_data.end_of_packet;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      flags_in    = flags_ff;
      type_in     = type_ff;
      length_in   = length_ff;
      tunnel_in   = tunnel_ff;
      seq_in      = seq_ff;
      npdu_in     = npdu_ff;
      udp_in      = udp_ff;
      pdcp_in     = pdcp_ff;
      present_in  = present_ff;
      ext_type_in = ext_type_ff;
      skip_in     = skip_ff;
      count_in    = count_ff;
      done        = 1'b0;
      err         = 1'b0;
      clear       = 1'b0;
      in_header   = 1'b0;
      push        = 1'b0;
      push_data   = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               push                     = 1'b1;
               push_data.record_kind    = gph_pkg::KIND_PAY;
               push_data.payload_byte   = b;
               push_data.last_of_packet = eop;
               clear                    = eop;
            end
            PH_DISCARD: begin
               clear = eop;
            end
            PH_FIXED: begin
               in_header = 1'b1;
               case (pos_ff)
                  4'd0: flags_in = b;
                  4'd1: type_in = b;
                  4'd2, 4'd3: length_in = {length_ff[7:0], b};
                  default: tunnel_in = {tunnel_ff[23:0], b};
               endcase
               pos_in = pos_ff + 4'd1;
               if (pos_ff == 4'd7) begin
                  if (flags_ff[2:0] != 3'd0) begin
                     phase_in   = PH_OPT;
                     present_in = {2'b00, flags_ff[1:0]};
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            PH_OPT: begin
               in_header = 1'b1;
               if (pos_ff <= 4'd9) begin
                  seq_in = {seq_ff[7:0], b};
               end else begin
                  npdu_in = b;
               end
               pos_in = pos_ff + 4'd1;
               if (pos_ff == 4'd10) begin
                  phase_in = PH_NEXT;
               end
            end
            PH_NEXT: begin
               in_header = 1'b1;
               if (!flags_ff[2] || b == 8'd0) begin
                  done = 1'b1;
               end else if (count_ff >= EXT_LIMIT) begin
                  err = 1'b1;
               end else begin
                  count_in    = count_ff + 1'b1;
                  ext_type_in = b;
                  phase_in    = PH_EXTLEN;
               end
            end
            PH_EXTLEN: begin
               in_header = 1'b1;
               if (b == 8'd0) begin
                  err = 1'b1;
               end else begin
                  if (b != 8'd1) begin
                     ext_type_in = 8'd0;
                  end
                  skip_in  = {b, 2'b00} - 10'd2;
                  phase_in = PH_EXTBODY;
               end
            end
            PH_EXTBODY: begin
               in_header = 1'b1;
               if (ext_type_ff != 8'd0 && skip_ff <= 10'd2) begin
                  if (ext_type_ff == cfg.udp_port_ext_type) begin
                     if (skip_ff == 10'd2) begin
                        udp_in = {b, 8'd0};
                     end else begin
                        udp_in     = {udp_ff[15:8], b};
                        present_in = present_ff | 4'b0100;
                     end
                  end else if (ext_type_ff == cfg.pdcp_number_ext_type) begin
                     if (skip_ff == 10'd2) begin
                        pdcp_in = {b, 8'd0};
                     end else begin
                        pdcp_in    = {pdcp_ff[15:8], b};
                        present_in = present_ff | 4'b1000;
                     end
                  end
               end
               if (skip_ff != 10'd0) begin
                  skip_in = skip_ff - 10'd1;
               end
               if (skip_in == 10'd0) begin
                  phase_in = PH_NEXT;
               end
            end
            default: begin
               clear = 1'b1;
            end
         endcase

         if (done) begin
            push                        = 1'b1;
            push_data.record_kind       = gph_pkg::KIND_HDR;
            push_data.last_of_packet    = eop;
            push_data.hdr_version       = flags_in[7:5];
            push_data.message_type      = type_in;
            push_data.message_length    = length_in;
            push_data.tunnel_id         = tunnel_in;
            push_data.present_flags     = present_in;
            push_data.sequence_number   = seq_in;
            push_data.npdu_number       = npdu_in;
            push_data.udp_port_value    = udp_in;
            push_data.pdcp_number_value = pdcp_in;
            clear                       = eop;
            phase_in                    = PH_PAYLOAD;
         end else if (in_header && (err || eop)) begin
            push                     = 1'b1;
            push_data.record_kind    = gph_pkg::KIND_ERR;
            push_data.last_of_packet = eop;
            clear                    = eop;
            phase_in                 = PH_DISCARD;
         end

         if (clear) begin
            phase_in    = PH_FIXED;
            pos_in      = 4'd0;
            seq_in      = 16'd0;
            npdu_in     = 8'd0;
            udp_in      = 16'd0;
            pdcp_in     = 16'd0;
            present_in  = 4'd0;
            ext_type_in = 8'd0;
            skip_in     = 10'd0;
            count_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIXED;
         pos_ff      <= 4'd0;
         seq_ff      <= 16'd0;
         npdu_ff     <= 8'd0;
         udp_ff      <= 16'd0;
         pdcp_ff     <= 16'd0;
         present_ff  <= 4'd0;
         ext_type_ff <= 8'd0;
         skip_ff     <= 10'd0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         seq_ff      <= seq_in;
         npdu_ff     <= npdu_in;
         udp_ff      <= udp_in;
         pdcp_ff     <= pdcp_in;
         present_ff  <= present_in;
         ext_type_ff <= ext_type_in;
         skip_ff     <= skip_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff  <= flags_in;
      type_ff   <= type_in;
      length_ff <= length_in;
      tunnel_ff <= tunnel_in;
   end

endmodule

// ----- sv/gph_fifo.sv -----
`timescale 1ns / 1ps
// Short record queue between the header front end and the output stage.
module gph_fifo #(
   parameter int DEPTH = gph_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gph_pkg::rsp_type   push_data,
   input  logic               pop,
   output gph_pkg::rsp_type   pop_data,
   output gph_pkg::qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   gph_pkg::rsp_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == FULL_CNT);
   assign qstat.empty = (count_ff == '0);
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/gph_back.sv -----
`timescale 1ns / 1ps
// Back end: formats queued records by kind and holds them in the output register.
module gph_back (
   input  logic               clock,
   input  logic               reset,
   input  gph_pkg::qstat_type qstat,
   input  gph_pkg::rsp_type   pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gph_pkg::rsp_type   rsp_data
);

   logic             valid_ff, valid_in;
   gph_pkg::rsp_type data_ff, data_in;
   gph_pkg::rsp_type formatted;

   always_comb begin
      formatted                = '0;
      formatted.record_kind    = pop_data.record_kind;
      formatted.last_of_packet = pop_data.last_of_packet;
      unique case (pop_data.record_kind)
         gph_pkg::KIND_HDR: begin
            formatted                   = pop_data;
            formatted.payload_byte      = 8'd0;
         end
         gph_pkg::KIND_PAY: begin
            formatted.payload_byte = pop_data.payload_byte;
         end
         default: begin
            formatted.record_kind = gph_pkg::KIND_ERR;
         end
      endcase
   end

   assign pop = !qstat.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = formatted;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- sv/gtpu_header_parser.sv -----
`timescale 1ns / 1ps
// Top level of the GTP-U header parser: register file, front end, record queue and output stage.
//
// The req channel carries one packet byte per beat with an end-of-packet mark.
// The rsp channel returns one header record per packet once its header is
// complete (fixed part, optional fields and extension chain), then one beat per
// payload byte. A truncated header, a zero extension length or too many
// extension headers returns an error record and drops the rest of the packet.
// Header bytes other than the one that completes the header return nothing.
// The csr channel writes the two extension type codes; csr_ready is always high.
// Throughput is one byte per cycle while req_stall is low. A record reaches rsp
// through the front end's queue write and then the output register. The record
// queue holds QUEUE_DEPTH records; req_stall rises only when it is full, so a
// stalled receiver backs up into req after the queue and the output register
// fill. Reset returns the parser to the start of a packet, empties the queue and
// output register, and restores the type codes.
module gtpu_header_parser #(
   parameter int MAX_EXT_HEADERS = gph_pkg::MAX_EXT_HEADERS_DEF,
   parameter int QUEUE_DEPTH     = gph_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gph_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gph_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gph_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data
);

   gph_pkg::cfg_type   cfg_ff, cfg_in;
   gph_pkg::qstat_type qstat;
   gph_pkg::rsp_type   push_data;
   gph_pkg::rsp_type   pop_data;
   logic               push;
   logic               pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gph_pkg::CSR_UDP_EXT_TYPE:  cfg_in.udp_port_ext_type    = csr_data;
            gph_pkg::CSR_PDCP_EXT_TYPE: cfg_in.pdcp_number_ext_type = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.udp_port_ext_type    <= gph_pkg::UDP_EXT_TYPE_RESET;
         cfg_ff.pdcp_number_ext_type <= gph_pkg::PDCP_EXT_TYPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gph_front #(
      .MAX_EXT_HEADERS(MAX_EXT_HEADERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   gph_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   gph_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
